// ===== src/deq_pkg.sv =====
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int IN_W   = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } stat_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fire;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic more;
    } sts_t;

endpackage

// ===== src/deq_ctrl.sv =====
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  deq_pkg::sts_t sts,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                // one result per free output slot, dump keeps going until its last entry
                if (sts.out_free)
                begin
                    cmd.fire = 1'b1;
                    if (!sts.more)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/deq_dp.sv =====
module deq_dp #(
    parameter  int DEPTH = 32,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  deq_pkg::cmd_t                       cmd,
    output deq_pkg::sts_t                       sts,
    input  logic [deq_pkg::OP_W-1:0]            in_op,
    input  logic signed [deq_pkg::DATA_W-1:0]   in_value,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [deq_pkg::STAT_W-1:0]          out_status,
    output logic signed [deq_pkg::DATA_W-1:0]   out_item,
    output logic signed [deq_pkg::DATA_W-1:0]   out_total,
    output logic [CNT_W-1:0]                    out_count,
    output logic                                out_last
);
    import deq_pkg::*;

    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                  logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (IDX_W+1)'(DEPTH))
        begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]         front_reg,  front_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic signed [DATA_W-1:0] total_reg,  total_next;
    logic [IDX_W-1:0]         walk_reg,   walk_next;
    op_t                      op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     out_valid_reg;
    stat_t                    out_status_reg;
    logic signed [DATA_W-1:0] out_item_reg;
    logic signed [DATA_W-1:0] out_total_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]         count_m1;
    logic                     full;
    logic                     empty;
    logic                     is_end;
    logic [IDX_W-1:0]         front_dec;
    logic [IDX_W-1:0]         rd_addr;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    stat_t                    res_status;
    logic signed [DATA_W-1:0] res_item;
    logic                     res_last;

    assign count_m1  = count_reg - 1'b1;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_end    = (CNT_W'(walk_reg) == count_m1);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.more     = (op_reg == OP_DUMP) && !empty && !is_end;

    // read address follows the next offset so rd_data_reg matches walk_reg while an operation is in progress
    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.load)
        begin
            if (op_t'(in_op) == OP_POP_BACK)
            begin
                walk_next = count_m1[IDX_W-1:0];
            end
            else
            begin
                walk_next = '0;
            end
        end
        else if (cmd.fire && sts.more)
        begin
            walk_next = walk_reg + 1'b1;
        end
    end

    assign rd_addr = wrap_add(front_reg, walk_next);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        total_next = total_reg;
        we         = 1'b0;
        waddr      = front_dec;
        res_status = ST_OK;
        res_item   = '0;
        res_last   = 1'b1;
        case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    total_next = total_reg + value_reg;
                    if (op_reg == OP_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                    end
                    else
                    begin
                        waddr = wrap_add(front_reg, count_reg[IDX_W-1:0]);
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_item   = rd_data_reg;
                    count_next = count_m1;
                    total_next = total_reg - rd_data_reg;
                    if (op_reg == OP_POP_FRONT)
                    begin
                        front_next = wrap_add(front_reg, IDX_W'(1));
                    end
                end
            end
            OP_DUMP:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_item = rd_data_reg;
                    res_last = is_end;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            walk_reg <= walk_next;
            if (cmd.fire)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
                total_reg <= total_next;
            end
            if (cmd.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(in_op);
            value_reg <= in_value;
        end
        if (cmd.fire)
        begin
            out_status_reg <= res_status;
            out_item_reg   <= res_item;
            out_total_reg  <= total_next;
            out_count_reg  <= count_next;
            out_last_reg   <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && cmd.fire)
        begin
            mem[waddr] <= value_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_item   = out_item_reg;
    assign out_total  = out_total_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a word not yet taken");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire && (op_reg == OP_PUSH_FRONT || op_reg == OP_PUSH_BACK) && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not grow the queue");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        sts.more |-> (CNT_W'(walk_reg) + 1'b1) < count_reg)
        else $error("dump walk beyond the stored entries");

endmodule

// ===== src/deque_with_running_sum.sv =====
// a push or pop word is registered when accepted, its result loads once the output slot is free
// a new word is taken only in the idle state, never while the previous one is still in progress
// a dump: one entry per cycle from the single memory read port unless stalled, one status if empty
// a stalled output holds the controller, the next word is taken once the result is loaded
// reset: rst_n low clears pointers, count, total and handshake state, memory is not cleared
module deque_with_running_sum #(
    parameter  int DEPTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((deq_pkg::STAT_W + 2 * deq_pkg::DATA_W + CNT_W + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // operation [2:0], value [34:3], zero pad to 40 bits
    input  logic [deq_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status [1:0], item [33:2], total [65:34], count, zero pad to whole bytes
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tlast
);
    import deq_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    logic [STAT_W-1:0]        out_status;
    logic signed [DATA_W-1:0] out_item;
    logic signed [DATA_W-1:0] out_total;
    logic [CNT_W-1:0]         out_count;

    // fsm: idle takes a word, busy loads one result per free output slot
    deq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // circular entry memory, pointers, running total and output register
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tdata[OP_W-1:0]),
        .in_value   (s_tdata[OP_W+DATA_W-1:OP_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_item   (out_item),
        .out_total  (out_total),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    // fields packed from the low end, upper bits zero
    assign m_tdata = OUT_W'({out_count, out_total, out_item, out_status});

endmodule

// ===== bench/tb_deque_with_running_sum.sv =====
`timescale 1ns / 1ps

module tb_deque_with_running_sum;
    import deq_pkg::*;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((STAT_W + 2 * DATA_W + CNT_W + 7) / 8) * 8;

    // operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int RANDOM_WORDS = 405;
    localparam int HOLD_AT      = 150;   // words sent before the long receiver stall
    localparam int LONG_HOLD    = 300;   // cycles of that stall
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        bit                settle;   // wait for every result before offering this word
    } op_word_t;

    typedef struct {
        stat_t             status;
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] total;
        logic [CNT_W-1:0]  count;
        logic              last;
    } deq_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // operation [2:0], value [34:3], zero pad to 40 bits
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // status [1:0], item [33:2], total [65:34], count [71:66]
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    op_word_t          ops_to_send[$];
    deq_result_t       results_due[$];

    // predicted deque contents
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int                shadow_front = 0;
    int                shadow_fill = 0;
    logic [DATA_W-1:0] shadow_sum = '0;

    int                plan_fill = 0;      // entry count the stimulus expects, for shaping
    int                total_words = 0;
    int                words_sent = 0;
    int                errors = 0;
    bit                in_taken = 1'b0;    // word on s_tdata was taken at the last rising edge
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    bit                offer;
    op_word_t          next_word;

    deque_with_running_sum #(.DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic note_result(input stat_t status, input logic [DATA_W-1:0] item,
                               input logic last);
        deq_result_t r;
        r.status = status;
        r.item   = item;
        r.total  = shadow_sum;
        r.count  = CNT_W'(shadow_fill);
        r.last   = last;
        results_due.push_back(r);
    endtask

    task automatic deque_apply_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] taken;
        int                i;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    // full, word dropped
                    note_result(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = value;
                    end
                    else
                    begin
                        shadow_store[(shadow_front + shadow_fill) % DEPTH] = value;
                    end
                    shadow_fill++;
                    shadow_sum = shadow_sum + value;
                    note_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_fill == 0)
                begin
                    note_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        taken = shadow_store[shadow_front];
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                    begin
                        taken = shadow_store[(shadow_front + shadow_fill - 1) % DEPTH];
                    end
                    // front index moves only on a front pop, also when the last entry goes
                    shadow_fill--;
                    shadow_sum = shadow_sum - taken;
                    note_result(ST_OK, taken, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (shadow_fill == 0)
                begin
                    note_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < shadow_fill; i++)
                    begin
                        note_result(ST_OK, shadow_store[(shadow_front + i) % DEPTH],
                                    i == shadow_fill - 1);
                    end
                end
            end
            default:
            begin
                // spare codes: plain status report
                note_result(ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result(input logic [OUT_W-1:0] data, input logic lst);
        deq_result_t want;
        logic [STAT_W-1:0] got_status;
        logic [DATA_W-1:0] got_item;
        logic [DATA_W-1:0] got_total;
        logic [CNT_W-1:0]  got_count;
        got_status = data[1:0];
        got_item   = data[33:2];
        got_total  = data[65:34];
        got_count  = data[66 +: CNT_W];
        if (results_due.size() == 0)
        begin
            $display("%0t: unexpected word status=%0d item=%h total=%h count=%0d last=%b",
                     $time, got_status, got_item, got_total, got_count, lst);
            errors++;
        end
        else
        begin
            want = results_due.pop_front();
            if (got_status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
                errors++;
            end
            if (got_item !== want.item)
            begin
                $display("%0t: item expected %h actual %h", $time, want.item, got_item);
                errors++;
            end
            if (got_total !== want.total)
            begin
                $display("%0t: total expected %h actual %h", $time, want.total, got_total);
                errors++;
            end
            if (got_count !== want.count)
            begin
                $display("%0t: count expected %0d actual %0d", $time, want.count, got_count);
                errors++;
            end
            if (lst !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, lst);
                errors++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                            input bit settle);
        op_word_t w;
        w.op     = op;
        w.value  = value;
        w.settle = settle;
        ops_to_send.push_back(w);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (plan_fill < DEPTH) plan_fill++;
            OP_POP_FRONT, OP_POP_BACK:   if (plan_fill > 0) plan_fill--;
            default: ;
        endcase
    endtask

    // mostly random values, with the extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_push();
        return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic logic [OP_W-1:0] pick_pop();
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // a settle point every hundred words so the sender drains the block now and then
    function automatic bit settle_here(input int base);
        return ((ops_to_send.size() - base) % 100) == 0;
    endfunction

    initial
    begin
        int base;
        int seg;
        int k;
        int r;
        int extra;
        logic [OP_W-1:0] op;

        // directed: extremes, wraparound of the sum, every code, empty and single-entry cases
        queue_op(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
        queue_op(OP_PUSH_BACK,  32'h7fff_ffff, 1'b0);
        queue_op(OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
        queue_op(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
        queue_op(OP_DUMP,       32'h0000_0000, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK,   32'hffff_ffff, 1'b0);
        queue_op(OP_SPARE_FIRST, 32'h1234_5678, 1'b0);
        queue_op(OP_SPARE_MID,  32'h0000_0000, 1'b0);
        queue_op(OP_SPARE_LAST, 32'hffff_ffff, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK,   32'h0000_0000, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);   // pop front on empty
        queue_op(OP_POP_BACK,   32'h0000_0000, 1'b0);   // pop back on empty
        queue_op(OP_DUMP,       32'h0000_0000, 1'b0);   // dump on empty
        queue_op(OP_PUSH_BACK,  32'h5555_5555, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);   // front pop of the only entry
        queue_op(OP_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);
        queue_op(OP_POP_BACK,   32'h0000_0000, 1'b0);   // back pop of the only entry
        queue_op(OP_DUMP,       32'h0000_0000, 1'b0);
        queue_op(OP_PUSH_BACK,  32'h0000_0001, 1'b0);
        queue_op(OP_PUSH_FRONT, 32'hffff_fffe, 1'b0);
        queue_op(OP_DUMP,       32'h0000_0000, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        queue_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);

        // random: fill, drain and mixed stretches; the first one fills to overflow
        base = ops_to_send.size();
        seg  = 0;
        while (ops_to_send.size() - base < RANDOM_WORDS)
        begin
            r = (seg == 0) ? 0 : $urandom_range(9);
            if (r <= 1)
            begin
                // fill until full, then push into the full deque and maybe dump it
                extra = $urandom_range(1, 3);
                while (plan_fill < DEPTH || extra > 0)
                begin
                    if (plan_fill == DEPTH)
                        extra--;
                    queue_op(pick_push(), pick_value(), settle_here(base));
                end
                if ($urandom_range(1))
                    queue_op(OP_DUMP, $urandom(), settle_here(base));
            end
            else if (r <= 3)
            begin
                // drain past empty
                extra = $urandom_range(1, 2);
                while (plan_fill > 0 || extra > 0)
                begin
                    if (plan_fill == 0)
                        extra--;
                    queue_op(pick_pop(), $urandom(), settle_here(base));
                end
            end
            else
            begin
                for (k = $urandom_range(10, 20); k > 0; k--)
                begin
                    r = $urandom_range(99);
                    if (r < 22)
                        op = OP_PUSH_FRONT;
                    else if (r < 44)
                        op = OP_PUSH_BACK;
                    else if (r < 64)
                        op = OP_POP_FRONT;
                    else if (r < 84)
                        op = OP_POP_BACK;
                    else if (r < 96)
                        op = OP_DUMP;
                    else
                        op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                    queue_op(op, pick_value(), settle_here(base));
                end
            end
            seg++;
        end
        total_words = ops_to_send.size();
    end

    // idle rates: sender light and receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        if (words_sent < total_words / 3)
            return 19;
        else if (words_sent < 2 * total_words / 3)
            return 73;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (words_sent < total_words / 3)
            return 73;
        else if (words_sent < 2 * total_words / 3)
            return 19;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: input side changes on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            offer = 1'b0;
            if (ops_to_send.size() != 0)
            begin
                // a settle word waits until the block has delivered everything
                if (!(ops_to_send[0].settle && results_due.size() != 0))
                    offer = ($urandom_range(99) >= sender_idle_pct());
            end
            if (offer)
            begin
                next_word = ops_to_send.pop_front();
                s_tdata  <= {{(IN_W - OP_W - DATA_W){1'b0}}, next_word.value, next_word.op};
                s_tvalid <= 1'b1;
                words_sent <= words_sent + 1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long stall to back the block up into its input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && words_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                deque_apply_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W]);
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        while (ops_to_send.size() != 0 || s_tvalid)
            @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/deque_with_running_sum.sv
bench/tb_deque_with_running_sum.sv
